>>> rtl/rt_pkg.sv
// Shared types and constants for the rank transform block.
package rt_pkg;

    localparam int VALUE_W          = 32;
    localparam int RANK_W           = 6;
    localparam int MAX_ELEMENTS_DEF = 64;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic store;    // word accepted on the item channel
        logic close;    // accepted word closes the set
        logic scan_rd;  // read the next stored value for the minimum search
        logic pick;     // commit the current minimum as the next rank
        logic emit_ld;  // load one result into the output register
    } rt_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic scan_last;  // scan index points at the last stored entry
        logic rank_last;  // rank being committed is the last of the set
        logic emit_last;  // emit index points at the last stored entry
        logic out_free;   // output register can take a result this cycle
    } rt_stat_t;

endpackage

>>> rtl/rt_ctrl.sv
// Controller state machine for the rank transform block.
module rt_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             last,
    output logic             item_stall,
    input  rt_pkg::rt_stat_t stat,
    output rt_pkg::rt_cmd_t  cmd
);
    import rt_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SCAN     = 3'd1;
    localparam logic [2:0] ST_SCAN_END = 3'd2;
    localparam logic [2:0] ST_PICK     = 3'd3;
    localparam logic [2:0] ST_EMIT_RD  = 3'd4;
    localparam logic [2:0] ST_EMIT_LD  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Take words only while collecting a set
    assign item_stall = (state_reg != ST_IDLE);

    // Decode state into commands and pick the next state
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.store = 1'b1;
                    if (last)
                    begin
                        cmd.close  = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END:
            begin
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = stat.rank_last ? ST_EMIT_RD : ST_SCAN;
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_ld = 1'b1;
                    state_next  = stat.emit_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/rt_datapath.sv
// Datapath for the rank transform block: stores, minimum search, output register.
module rt_datapath #(
    parameter int MAX_ELEMENTS = rt_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  rt_pkg::rt_cmd_t                  cmd,
    output rt_pkg::rt_stat_t                 stat,
    input  logic signed [rt_pkg::VALUE_W-1:0] value,
    output logic                             res_valid,
    input  logic                             res_stall,
    output logic [rt_pkg::RANK_W-1:0]        rank,
    output logic                             final_res,
    output logic                             overflow
);
    import rt_pkg::*;

    localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

    // Value and rank memories
    logic signed [VALUE_W-1:0] value_mem [MAX_ELEMENTS];
    logic [RANK_W-1:0]         rank_mem  [MAX_ELEMENTS];
    logic signed [VALUE_W-1:0] val_rd_reg;
    logic [RANK_W-1:0]         rank_rd_reg;

    logic [MAX_ELEMENTS-1:0]   chosen_reg;
    logic [CNT_W-1:0]          count_reg;
    logic                      dropped_reg;
    logic [IDX_W-1:0]          j_reg;
    logic [IDX_W-1:0]          j_d_reg;
    logic                      cmp_valid_reg;
    logic [CNT_W-1:0]          r_reg;
    logic [IDX_W-1:0]          k_reg;
    logic                      have_reg;
    logic [IDX_W-1:0]          best_reg;
    logic signed [VALUE_W-1:0] best_val_reg;
    logic                      room;
    logic                      better;
    logic                      clear_set;

    logic                      out_valid_reg;
    logic [RANK_W-1:0]         rank_reg;
    logic                      final_reg;
    logic                      overflow_reg;

    assign room      = (count_reg < CNT_W'(MAX_ELEMENTS));
    assign clear_set = cmd.emit_ld && stat.emit_last;
    assign better    = cmp_valid_reg && !chosen_reg[j_d_reg]
                       && (!have_reg || (val_rd_reg < best_val_reg));

    // Report loop positions to the controller
    assign stat.scan_last = ((CNT_W'(j_reg) + CNT_W'(1)) == count_reg);
    assign stat.rank_last = ((r_reg + CNT_W'(1)) == count_reg);
    assign stat.emit_last = ((CNT_W'(k_reg) + CNT_W'(1)) == count_reg);
    assign stat.out_free  = !out_valid_reg || !res_stall;

    // Write values on store, read one entry per cycle for the search
    always_ff @(posedge clk)
    begin
        if (cmd.store && room)
        begin
            value_mem[count_reg[IDX_W-1:0]] <= value;
        end
        val_rd_reg <= value_mem[j_reg];
    end

    // Write ranks on pick, read back for emission
    always_ff @(posedge clk)
    begin
        if (cmd.pick)
        begin
            rank_mem[best_reg] <= RANK_W'(r_reg);
        end
        rank_rd_reg <= rank_mem[k_reg];
    end

    // Hold the running minimum
    always_ff @(posedge clk)
    begin
        if (better)
        begin
            best_reg     <= j_d_reg;
            best_val_reg <= val_rd_reg;
        end
    end

    // Control counters and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chosen_reg    <= '0;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            j_reg         <= '0;
            j_d_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            r_reg         <= '0;
            k_reg         <= '0;
            have_reg      <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= cmd.scan_rd;
            j_d_reg       <= j_reg;

            // Collect the set
            if (cmd.store)
            begin
                if (room)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                else
                begin
                    dropped_reg <= 1'b1;
                end
            end

            if (cmd.close)
            begin
                j_reg    <= '0;
                r_reg    <= '0;
                k_reg    <= '0;
                have_reg <= 1'b0;
            end

            // Step the scan
            if (cmd.scan_rd)
            begin
                j_reg <= j_reg + IDX_W'(1);
            end

            if (better)
            begin
                have_reg <= 1'b1;
            end

            // Commit the minimum and restart the scan
            if (cmd.pick)
            begin
                chosen_reg[best_reg] <= 1'b1;
                r_reg                <= r_reg + CNT_W'(1);
                j_reg                <= '0;
                have_reg             <= 1'b0;
            end

            if (cmd.emit_ld)
            begin
                k_reg <= k_reg + IDX_W'(1);
            end

            // Drop the set once its last result is loaded
            if (clear_set)
            begin
                chosen_reg  <= '0;
                count_reg   <= '0;
                dropped_reg <= 1'b0;
                k_reg       <= '0;
            end
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_ld)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit_ld)
        begin
            rank_reg     <= rank_rd_reg;
            final_reg    <= stat.emit_last;
            overflow_reg <= dropped_reg;
        end
    end

    assign res_valid = out_valid_reg;
    assign rank      = rank_reg;
    assign final_res = final_reg;
    assign overflow  = overflow_reg;

endmodule

>>> rtl/rank_transform_top.sv
// Top level of the rank transform block.
//
// Values arrive one word per item; the word with last high closes the set. Up to
// MAX_ELEMENTS values are stored, later ones are dropped and every result of that
// set then carries overflow. Once the set closes, the block ranks the n stored
// values by repeated minimum selection (equal values rank in arrival order) and
// emits one rank per stored value in arrival order, final_res on the last one.
// Ranking scans the value store once per rank, one entry per cycle through its
// single read port; emission reads each result from the rank store and then loads
// it into the output register once that register is free to take it. Items
// are stalled from the closing word until the last result is loaded into the
// output register.
module rank_transform_top #(
    parameter int MAX_ELEMENTS = rt_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic signed [rt_pkg::VALUE_W-1:0] value,
    input  logic                              last,
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic [rt_pkg::RANK_W-1:0]         rank,
    output logic                              final_res,
    output logic                              overflow
);
    import rt_pkg::*;

    rt_cmd_t  cmd;
    rt_stat_t stat;

    rt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .last       (last),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    rt_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .value     (value),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .rank      (rank),
        .final_res (final_res),
        .overflow  (overflow)
    );

endmodule

>>> rtl/rt_checker.sv
// Port-level checks for the rank transform block and their bind.
module rt_checker #(
    parameter int MAX_ELEMENTS = rt_pkg::MAX_ELEMENTS_DEF
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              item_valid,
    input logic                              item_stall,
    input logic signed [rt_pkg::VALUE_W-1:0] value,
    input logic                              last,
    input logic                              res_valid,
    input logic                              res_stall,
    input logic [rt_pkg::RANK_W-1:0]         rank,
    input logic                              final_res,
    input logic                              overflow
);
    import rt_pkg::*;

    // Hold a stalled input word
    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |=> item_valid && $stable(value) && $stable(last))
        else $error("stalled input word changed");

    // Hold a stalled result word
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(rank)
            && $stable(final_res) && $stable(overflow))
        else $error("stalled result word changed");

    // Keep ranks below capacity
    a_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (int'(rank) < MAX_ELEMENTS))
        else $error("rank beyond capacity");

    // Go busy after the closing word
    a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && last |=> item_stall)
        else $error("item taken while ranking a closed set");

    // Stay busy while results of the set remain
    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !final_res |-> item_stall)
        else $error("item channel open before the set is emitted");

endmodule

bind rank_transform_top rt_checker #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
) u_rt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .value      (value),
    .last       (last),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .rank       (rank),
    .final_res  (final_res),
    .overflow   (overflow)
);

>>> sim/rank_transform_top_tb.sv
// Self-checking testbench for the rank transform block: sets, ranks, overflow.
module rank_transform_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rt_pkg::*;

    localparam int CAPACITY     = MAX_ELEMENTS_DEF;
    localparam int TARGET_WORDS = 410;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 200;

    localparam logic signed [VALUE_W-1:0] INT_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] INT_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic              final_res;
        logic              overflow;
    } rank_word_t;

    // Ranks of each closed set, kept in arrival order
    class rank_scoreboard;
        logic signed [VALUE_W-1:0] set_values[$];
        bit                        set_dropped;
        rank_word_t                pending_ranks[$];
        int                        errors;
        int                        results_seen;

        function new();
            set_dropped  = 0;
            errors       = 0;
            results_seen = 0;
        endfunction

        // Store an accepted word; on the closing word work out every rank
        function void note_word(logic signed [VALUE_W-1:0] v, logic l);
            int         n;
            int         r;
            rank_word_t w;
            if (set_values.size() < CAPACITY)
                set_values.push_back(v);
            else
                set_dropped = 1;
            if (l)
            begin
                n = set_values.size();
                // rank = entries below, plus equal entries that arrived earlier
                for (int k = 0; k < n; k++)
                begin
                    r = 0;
                    for (int j = 0; j < n; j++)
                        if (set_values[j] < set_values[k] ||
                            (set_values[j] == set_values[k] && j < k))
                            r++;
                    w.rank      = r[RANK_W-1:0];
                    w.final_res = (k == n - 1);
                    w.overflow  = set_dropped;
                    pending_ranks.push_back(w);
                end
                set_values.delete();
                set_dropped = 0;
            end
        endfunction

        // Compare one accepted result word with the oldest pending rank
        function void check_rank(logic [RANK_W-1:0] rk, logic fr, logic ov);
            rank_word_t w;
            results_seen++;
            if (pending_ranks.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result rank=%0d final_res=%0b overflow=%0b",
                         $time, rk, fr, ov);
                return;
            end
            w = pending_ranks.pop_front();
            if (rk !== w.rank)
            begin
                errors++;
                $display("%0t: rank expected %0d actual %0d", $time, w.rank, rk);
            end
            if (fr !== w.final_res)
            begin
                errors++;
                $display("%0t: final_res expected %0b actual %0b", $time, w.final_res, fr);
            end
            if (ov !== w.overflow)
            begin
                errors++;
                $display("%0t: overflow expected %0b actual %0b", $time, w.overflow, ov);
            end
        endfunction

        function int pending();
            return pending_ranks.size();
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        item_valid;
    logic                        item_stall;
    logic signed [VALUE_W-1:0]   value;
    logic                        last;
    logic                        res_valid;
    logic                        res_stall;
    logic [RANK_W-1:0]           rank;
    logic                        final_res;
    logic                        overflow;

    rank_scoreboard ranks;
    int             cycles;
    int             words_sent;
    int             sets_sent;
    int             overflow_sets;
    int             send_mode;

    rank_transform_top #(
        .MAX_ELEMENTS (CAPACITY)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .value      (value),
        .last       (last),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .rank       (rank),
        .final_res  (final_res),
        .overflow   (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Mostly short gaps, a few long ones; mode 0 means no idling at all
    function automatic int pick_gap(int mode);
        int r;
        if (mode == 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Value of one element: full range, narrow range with ties, or extremes
    function automatic logic signed [VALUE_W-1:0] pick_value(int kind);
        case (kind)
            0: return $urandom;
            1: return $signed($urandom_range(0, 7)) - 4;
            default:
            begin
                case ($urandom_range(0, 4))
                    0: return INT_MIN;
                    1: return INT_MAX;
                    2: return 0;
                    3: return -1;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    // Count the cycles and stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d ranks pending", cycles, ranks.pending());
            $display("rank_transform_top_tb: done, errors");
            $finish;
        end
    end

    // Check every accepted result word
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            ranks.check_rank(rank, final_res, overflow);
    end

    // Stall the result side in bursts, switching the pattern now and then
    initial
    begin : result_stall
        int stall_left;
        int stall_mode;
        int mode_left;
        res_stall  = 1'b0;
        stall_left = 0;
        stall_mode = 0;
        mode_left  = 0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(50, 400);
            end
            mode_left--;
            if (stall_left == 0)
                stall_left = pick_gap(stall_mode);
            if (stall_left != 0)
                stall_left--;
            res_stall <= (stall_left != 0);
        end
    end

    // Present one word after a random gap and hold it until accepted
    task automatic send_word(input logic signed [VALUE_W-1:0] v, input logic l);
        int gap;
        gap = pick_gap(send_mode);
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        value      <= v;
        last       <= l;
        do
            @(posedge clk);
        while (item_stall);
        ranks.note_word(v, l);
        words_sent++;
        if (l)
            sets_sent++;
    endtask

    task automatic send_set(input int n, input int kind);
        send_mode = $urandom_range(0, 2);
        if (n > CAPACITY)
            overflow_sets++;
        for (int k = 0; k < n; k++)
            send_word(pick_value(kind), k == n - 1);
    endtask

    initial
    begin : main
        int r;
        int n;
        ranks         = new();
        cycles        = 0;
        words_sent    = 0;
        sets_sent     = 0;
        overflow_sets = 0;
        send_mode     = 0;
        rst_n         = 1'b0;
        item_valid    = 1'b0;
        value         = '0;
        last          = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Single-element set holding the most negative value
        send_word(INT_MIN, 1'b1);
        // Extremes mixed with ties of both extremes
        send_mode = 1;
        send_word(INT_MAX, 1'b0);
        send_word(INT_MIN, 1'b0);
        send_word(0, 1'b0);
        send_word(-1, 1'b0);
        send_word(1, 1'b0);
        send_word(INT_MAX, 1'b0);
        send_word(INT_MIN, 1'b1);
        // All equal: ranks follow arrival order
        send_mode = 0;
        send_word(5, 1'b0);
        send_word(5, 1'b0);
        send_word(5, 1'b0);
        send_word(5, 1'b1);
        // Alternating bit patterns drive every value bit both ways
        send_mode = 2;
        send_word(32'shAAAAAAAA, 1'b0);
        send_word(32'sh55555555, 1'b0);
        send_word(3, 1'b0);
        send_word(-3, 1'b1);
        // Strictly descending set
        send_word(100, 1'b0);
        send_word(50, 1'b0);
        send_word(-50, 1'b1);

        // Full set, then a set past capacity whose closing word is dropped
        send_set(CAPACITY, 0);
        send_set(CAPACITY + 2, 1);

        // Random sets, mostly small
        while (words_sent < TARGET_WORDS)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                n = $urandom_range(1, 8);
            else if (r < 85)
                n = $urandom_range(9, 24);
            else if (r < 93)
                n = $urandom_range(25, CAPACITY);
            else
                n = $urandom_range(CAPACITY + 1, CAPACITY + 6);
            send_set(n, $urandom_range(0, 2));
        end
        @(negedge clk);
        item_valid <= 1'b0;

        // Drain the pending ranks, then watch for stray results
        while (ranks.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d sets, %0d words, %0d ranks checked, %0d sets over capacity",
                 sets_sent, words_sent, ranks.results_seen, overflow_sets);
        $display("mismatches: %0d, %0d ranks left pending", ranks.errors, ranks.pending());
        if (ranks.errors == 0 && ranks.pending() == 0)
            $display("rank_transform_top_tb: done, clean");
        else
            $display("rank_transform_top_tb: done, errors");
        $finish;
    end

endmodule
